[rtl/vra_pkg.sv]
package vra_pkg;

  // Number of values one batch can hold.
  localparam int unsigned Depth = 64;

  localparam int unsigned IdxW  = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW  = $clog2(Depth + 1);
  localparam int unsigned ValW  = 32;
  localparam int unsigned RankW = 6;
  localparam int unsigned OutDataW = 8;

  // XOR with this maps a two's-complement word onto an unsigned key of the same order.
  localparam logic [ValW-1:0] SignFlip = {1'b1, {(ValW-1){1'b0}}};

endpackage

[rtl/value_rank_assigner.sv]
// Rank transform of a batch of signed 32-bit values.
//
// Input channel (s_axis): one value per transfer in tdata, tlast marks the
// final value of the batch. Up to 64 values are kept in load order; further
// values of the same batch are dropped and the batch is flagged as overflowed.
// Output channel (m_axis): after the closing transfer, one result per stored
// value, in load order. tdata carries the rank (0 for the smallest value, equal
// values ranked in load order), tlast marks the result of the last stored
// value and tuser is the overflow flag of the batch, equal on all its results.
//
// Timing: a value is taken every cycle while the batch is loading. Ranking a
// batch of n values takes n passes over the value memory, since the single
// read port of that memory delivers one value per cycle to the minimum search.
// Each result is then read from the rank memory (StEmitRd) and placed in the
// output register (StEmitWr) once that register is free, before the next is read.
//
// s_axis_tready_o is low from the closing transfer until the last result has
// been placed in the output register; the next batch may start loading while
// that result still waits. A stalled receiver simply holds the block in the
// output phase. Reset clears the counters and the output valid; the memories
// are not cleared and need not be. Each value word carries its ranked flag,
// which is cleared when the value is loaded and set when it gets its rank.
module value_rank_assigner (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // [31:0] value
  input  logic [vra_pkg::ValW-1:0]       s_axis_tdata_i,
  input  logic                           s_axis_tlast_i,
  input  logic                           s_axis_tvalid_i,
  output logic                           s_axis_tready_o,
  // [5:0] rank, [7:6] zero
  output logic [vra_pkg::OutDataW-1:0]   m_axis_tdata_o,
  // overflow
  output logic                           m_axis_tuser_o,
  output logic                           m_axis_tlast_o,
  output logic                           m_axis_tvalid_o,
  input  logic                           m_axis_tready_i
);
  import vra_pkg::*;

  typedef enum logic [2:0] {
    StLoad,
    StScan,
    StCommit,
    StEmitRd,
    StEmitWr
  } state_e;

  state_e            state_q;
  logic [CntW-1:0]   cnt_q;      // values stored in this batch
  logic              ovf_q;
  logic [CntW-1:0]   rank_q;     // rank handed out by the current pass
  logic [CntW-1:0]   scan_q;     // next address of the current pass
  logic              rd_vld_q;
  logic              rd_last_q;
  logic [IdxW-1:0]   rd_idx_q;
  logic              found_q;
  logic [IdxW-1:0]   best_q;
  logic [ValW-1:0]   best_key_q;
  logic [CntW-1:0]   emit_q;
  logic [RankW-1:0]  out_rank_q;
  logic              out_last_q;
  logic              out_ovf_q;
  logic              out_vld_q;

  logic              in_xfer;
  logic              store_we;
  logic              scan_issue;
  logic              val_we;
  logic [IdxW-1:0]   val_waddr;
  logic [ValW:0]     val_wdata;
  logic [ValW:0]     val_rdata;
  logic [ValW-1:0]   cand_key;
  logic              cand_take;
  logic              commit;
  logic [RankW-1:0]  rank_rdata;
  logic              out_free;
  logic              emit_last;

  assign in_xfer    = s_axis_tvalid_i && s_axis_tready_o;
  assign store_we   = in_xfer && (cnt_q < CntW'(Depth));
  assign scan_issue = (state_q == StScan) && (scan_q < cnt_q);
  assign commit     = (state_q == StCommit);
  assign out_free   = !out_vld_q || m_axis_tready_i;
  assign emit_last  = (emit_q == cnt_q - CntW'(1));

  // The top bit of a value word is its ranked flag. Loading writes the value
  // with the flag clear; the commit of a pass writes the winner back with the
  // flag set. Loading and committing never happen in the same cycle.
  assign val_we    = store_we || commit;
  assign val_waddr = commit ? best_q : cnt_q[IdxW-1:0];
  assign val_wdata = commit ? {1'b1, best_key_q ^ SignFlip} : {1'b0, s_axis_tdata_i};

  // The minimum search sees one value per cycle, in the cycle after its read.
  assign cand_key  = val_rdata[ValW-1:0] ^ SignFlip;
  assign cand_take = rd_vld_q && !val_rdata[ValW] &&
                     (!found_q || (cand_key < best_key_q));

  vra_ram #(
    .Width (ValW + 1),
    .Depth (Depth)
  ) u_value_ram (
    .clk_i   (clk_i),
    .we_i    (val_we),
    .waddr_i (val_waddr),
    .wdata_i (val_wdata),
    .re_i    (scan_issue),
    .raddr_i (scan_q[IdxW-1:0]),
    .rdata_o (val_rdata)
  );

  // Ranks are written only during ranking and read only while emitting, so
  // the two accesses never meet on one entry.
  vra_ram #(
    .Width (RankW),
    .Depth (Depth)
  ) u_rank_ram (
    .clk_i   (clk_i),
    .we_i    (commit),
    .waddr_i (best_q),
    .wdata_i (RankW'(rank_q)),
    .re_i    (state_q == StEmitRd),
    .raddr_i (emit_q[IdxW-1:0]),
    .rdata_o (rank_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= StLoad;
      cnt_q      <= '0;
      ovf_q      <= 1'b0;
      rank_q     <= '0;
      scan_q     <= '0;
      rd_vld_q   <= 1'b0;
      rd_last_q  <= 1'b0;
      rd_idx_q   <= '0;
      found_q    <= 1'b0;
      best_q     <= '0;
      best_key_q <= '0;
      emit_q     <= '0;
      out_rank_q <= '0;
      out_last_q <= 1'b0;
      out_ovf_q  <= 1'b0;
      out_vld_q  <= 1'b0;
    end else begin
      if ((state_q == StEmitWr) && out_free) begin
        out_vld_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_vld_q <= 1'b0;
      end

      rd_vld_q  <= scan_issue;
      rd_idx_q  <= scan_q[IdxW-1:0];
      rd_last_q <= (scan_q == cnt_q - CntW'(1));

      case (state_q)
        StLoad: begin
          if (in_xfer) begin
            if (store_we) begin
              cnt_q <= cnt_q + CntW'(1);
            end else begin
              ovf_q <= 1'b1;
            end
            if (s_axis_tlast_i) begin
              state_q <= StScan;
              rank_q  <= '0;
              scan_q  <= '0;
              found_q <= 1'b0;
            end
          end
        end
        StScan: begin
          if (scan_issue) begin
            scan_q <= scan_q + CntW'(1);
          end
          if (cand_take) begin
            found_q    <= 1'b1;
            best_q     <= rd_idx_q;
            best_key_q <= cand_key;
          end
          if (rd_vld_q && rd_last_q) begin
            state_q <= StCommit;
          end
        end
        StCommit: begin
          rank_q  <= rank_q + CntW'(1);
          scan_q  <= '0;
          found_q <= 1'b0;
          if (rank_q == cnt_q - CntW'(1)) begin
            state_q <= StEmitRd;
            emit_q  <= '0;
          end else begin
            state_q <= StScan;
          end
        end
        StEmitRd: begin
          state_q <= StEmitWr;
        end
        StEmitWr: begin
          if (out_free) begin
            out_rank_q <= rank_rdata;
            out_last_q <= emit_last;
            out_ovf_q  <= ovf_q;
            if (emit_last) begin
              // Batch done: clear its state so the next batch can load.
              state_q <= StLoad;
              cnt_q   <= '0;
              ovf_q   <= 1'b0;
            end else begin
              emit_q  <= emit_q + CntW'(1);
              state_q <= StEmitRd;
            end
          end
        end
        default: begin
          state_q <= StLoad;
        end
      endcase
    end
  end

  assign s_axis_tready_o = (state_q == StLoad);
  assign m_axis_tdata_o  = OutDataW'(out_rank_q);
  assign m_axis_tuser_o  = out_ovf_q;
  assign m_axis_tlast_o  = out_last_q;
  assign m_axis_tvalid_o = out_vld_q;

endmodule

[rtl/vra_ram.sv]
module vra_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 64,
  parameter int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // Read data holds until the next read is issued.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/vra_checker.sv]
module vra_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic [vra_pkg::ValW-1:0]      s_axis_tdata_i,
  input logic                          s_axis_tlast_i,
  input logic                          s_axis_tvalid_i,
  input logic                          s_axis_tready_o,
  input logic [vra_pkg::OutDataW-1:0]  m_axis_tdata_o,
  input logic                          m_axis_tuser_o,
  input logic                          m_axis_tlast_o,
  input logic                          m_axis_tvalid_o,
  input logic                          m_axis_tready_i
);
  import vra_pkg::*;

  // Reset empties the output register at once.
  a_reset_no_valid: assert property (@(posedge clk_i)
    !rst_ni |-> !m_axis_tvalid_o)
    else $error("output valid during reset");

  // A closing transfer stops intake until the last result has been placed in the output register.
  a_close_blocks_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o && s_axis_tlast_i |=> !s_axis_tready_o)
    else $error("input taken right after batch close");

  // Intake is open only while any waiting result is the final one of its batch.
  a_mid_batch_no_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready_o && m_axis_tvalid_o |-> m_axis_tlast_o)
    else $error("input taken while a batch is still being emitted");

  // A stalled result holds its contents.
  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=>
      m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tlast_o) &&
      $stable(m_axis_tuser_o))
    else $error("stalled result changed");

  // The pad bits above the rank are always zero.
  a_pad_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> (m_axis_tdata_o[OutDataW-1:RankW] == '0))
    else $error("nonzero pad bits in result");

endmodule

bind value_rank_assigner vra_checker u_vra_checker (.*);

[bench/value_rank_assigner_test.sv]
`timescale 1ns / 100ps

// Checks the rank transform of value_rank_assigner. Each accepted value that fits
// the store goes into a local copy of the batch. When a batch closes, the bench ranks
// that copy itself and queues one expected result per stored value, in load order.
// A separate process takes the results from the output stream and compares each one,
// field by field, with the oldest result still queued. Both stream sides pause at
// random, with some stretches where they never pause.
module value_rank_assigner_test;
  import vra_pkg::*;

  // Ranking a full batch runs with no transfer on either side.
  localparam int unsigned QuietLimit = 20000;
  localparam int unsigned ItemTarget = 410;
  localparam int unsigned MaxReports = 40;

  localparam logic [ValW-1:0] BoundaryValues [4] = '{
    32'h8000_0000, 32'h7fff_ffff, 32'h0000_0000, 32'hffff_ffff
  };

  typedef struct packed {
    logic [RankW-1:0] rank;
    logic             last;
    logic             overflow;
  } rank_result_t;

  logic                clk_i           = 1'b0;
  logic                rst_ni          = 1'b1;
  logic [ValW-1:0]     s_axis_tdata_i  = '0;
  logic                s_axis_tlast_i  = 1'b0;
  logic                s_axis_tvalid_i = 1'b0;
  logic                s_axis_tready_o;
  logic [OutDataW-1:0] m_axis_tdata_o;
  logic                m_axis_tuser_o;
  logic                m_axis_tlast_o;
  logic                m_axis_tvalid_o;
  logic                m_axis_tready_i = 1'b0;

  value_rank_assigner dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tlast_i  (s_axis_tlast_i),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o),
    .m_axis_tlast_o  (m_axis_tlast_o),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i)
  );

  // Local copy of the batch being loaded.
  logic signed [ValW-1:0] batch_values [Depth];
  int unsigned            batch_count    = 0;
  bit                     batch_overflow = 1'b0;

  rank_result_t pending_ranks [$];

  int unsigned items_sent   = 0;
  int unsigned errors       = 0;
  int unsigned sink_stall   = 0;
  int unsigned quiet_cycles = 0;
  bit          send_gaps    = 1'b1;
  bit          sink_stalls  = 1'b1;

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  // Stores one accepted value, or marks the batch overflowed once the copy is full.
  // On the closing value it ranks the batch. The rank of entry i is the number of
  // smaller entries plus the number of equal entries loaded before it.
  function automatic void accept_value(logic signed [ValW-1:0] v, logic lst);
    rank_result_t res;
    int unsigned  r;
    if (batch_count < Depth) begin
      batch_values[batch_count] = v;
      batch_count++;
    end else begin
      batch_overflow = 1'b1;
    end
    if (lst) begin
      for (int i = 0; i < batch_count; i++) begin
        r = 0;
        for (int j = 0; j < batch_count; j++) begin
          if (batch_values[j] < batch_values[i] ||
              (batch_values[j] == batch_values[i] && j < i)) begin
            r++;
          end
        end
        res.rank     = r[RankW-1:0];
        res.last     = (i == batch_count - 1);
        res.overflow = batch_overflow;
        pending_ranks.push_back(res);
      end
      batch_count    = 0;
      batch_overflow = 1'b0;
    end
  endfunction

  task automatic report_mismatch(input string field, input logic [31:0] got,
                                 input logic [31:0] want);
    errors++;
    if (errors <= MaxReports) begin
      $display("%0t: %s mismatch, got %0h, expected %0h", $time, field, got, want);
    end
  endtask

  task automatic check_result();
    rank_result_t want;
    if (pending_ranks.size() == 0) begin
      report_mismatch("unexpected result", 32'(m_axis_tdata_o), 32'd0);
      return;
    end
    want = pending_ranks.pop_front();
    if (m_axis_tdata_o !== {{(OutDataW-RankW){1'b0}}, want.rank}) begin
      report_mismatch("rank", 32'(m_axis_tdata_o), 32'(want.rank));
    end
    if (m_axis_tlast_o !== want.last) begin
      report_mismatch("last", 32'(m_axis_tlast_o), 32'(want.last));
    end
    if (m_axis_tuser_o !== want.overflow) begin
      report_mismatch("overflow", 32'(m_axis_tuser_o), 32'(want.overflow));
    end
  endtask

  // Result side. After each transfer it draws a new stall length. tready gets one
  // assignment per edge.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (m_axis_tvalid_o && m_axis_tready_i) begin
        check_result();
        sink_stall = sink_stalls ? $urandom_range(9, 0) : 0;
      end
      if (sink_stall != 0) begin
        m_axis_tready_i <= 1'b0;
        sink_stall--;
      end else begin
        m_axis_tready_i <= 1'b1;
      end
    end
  end

  // Ends the run when no transfer happens on either side for too long.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_axis_tvalid_i && s_axis_tready_o) || (m_axis_tvalid_o && m_axis_tready_i)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= QuietLimit) begin
        $display("[value_rank_assigner] ERROR");
        $finish;
      end
    end
  end

  // Sends one value and returns at the edge where it is accepted. tvalid is left
  // high, so that a next value sent with no gap follows directly.
  task automatic send_value(input logic [ValW-1:0] v, input logic lst);
    int unsigned gap;
    gap = send_gaps ? $urandom_range(9, 0) : 0;
    if (gap != 0) begin
      s_axis_tvalid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tdata_i  <= v;
    s_axis_tlast_i  <= lst;
    s_axis_tvalid_i <= 1'b1;
    do @(posedge clk_i); while (!s_axis_tready_o);
    accept_value(v, lst);
    items_sent++;
  endtask

  // Called at the edge of the last accepted transfer, so tvalid drops only once.
  task automatic idle_input();
    s_axis_tvalid_i <= 1'b0;
    s_axis_tlast_i  <= 1'b0;
  endtask

  // Mixes wide random words, small values that repeat often, the boundary values,
  // and words close to the sign boundary.
  function automatic logic [ValW-1:0] draw_value();
    case ($urandom_range(3, 0))
      0:       return $urandom();
      1:       return $urandom_range(15, 0) - 32'd8;
      2:       return BoundaryValues[$urandom_range(3, 0)];
      default: return ($urandom() & 32'h8000_00ff) |
                      ($urandom_range(1, 0) ? 32'h7fff_ff00 : 32'h0);
    endcase
  endfunction

  task automatic send_batch(input int unsigned size);
    for (int i = 0; i < size; i++) begin
      send_value(draw_value(), i == size - 1);
    end
  endtask

  // A batch of one value.
  task automatic test_single_value();
    send_value(32'h8000_0000, 1'b1);
    idle_input();
  endtask

  // Both extremes, appearing twice, together with the values around zero.
  task automatic test_extremes();
    send_value(32'h7fff_ffff, 1'b0);
    send_value(32'h8000_0000, 1'b0);
    send_value(32'h0000_0000, 1'b0);
    send_value(32'hffff_ffff, 1'b0);
    send_value(32'h0000_0001, 1'b0);
    send_value(32'h7fff_ffff, 1'b0);
    send_value(32'h8000_0000, 1'b1);
    idle_input();
  endtask

  // Equal values must rank in load order. A two-value batch is also sent.
  task automatic test_equal_values();
    send_value(32'd5, 1'b0);
    send_value(32'd5, 1'b0);
    send_value(-32'sd3, 1'b0);
    send_value(32'd5, 1'b0);
    send_value(-32'sd3, 1'b1);
    send_value(32'd9, 1'b0);
    send_value(32'd9, 1'b1);
    idle_input();
  endtask

  // A batch that exactly fills the store, sent with no pauses on either side.
  // Then a batch whose closing value is dropped, and then a batch with several
  // values dropped.
  task automatic test_full_store();
    send_gaps   = 1'b0;
    sink_stalls = 1'b0;
    send_batch(Depth);
    send_gaps   = 1'b1;
    sink_stalls = 1'b1;
    send_batch(Depth + 1);
    send_batch(Depth + 6);
    idle_input();
  endtask

  // Mostly short batches with random content. Some have middle length and a few
  // overflow. Each side runs without pauses in about a quarter of the batches.
  task automatic test_random_batches();
    int unsigned pick;
    int unsigned size;
    while (items_sent < ItemTarget) begin
      send_gaps   = ($urandom_range(3, 0) != 0);
      sink_stalls = ($urandom_range(3, 0) != 0);
      pick = $urandom_range(99, 0);
      if (pick < 80) begin
        size = $urandom_range(12, 1);
      end else if (pick < 96) begin
        size = $urandom_range(40, 13);
      end else begin
        size = $urandom_range(Depth + 3, Depth - 1);
      end
      send_batch(size);
    end
    idle_input();
  endtask

  initial begin
    rst_ni <= 1'b0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_single_value();
    test_extremes();
    test_equal_values();
    test_full_store();
    test_random_batches();

    while (pending_ranks.size() != 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);

    if (errors == 0) begin
      $display("[value_rank_assigner] OK");
    end else begin
      $display("[value_rank_assigner] ERROR");
    end
    $finish;
  end

endmodule
